FILE: rtl/slbseq_pkg.sv
// ----------------------------------------------------------------------------
// slbseq_pkg
// Shared types and constants for the status LED blink sequencer.
// ----------------------------------------------------------------------------
package slbseq_pkg;

	// Timing register values, in milliseconds.
	localparam int unsigned TimeW = 16;
	localparam int unsigned CountW = 8;
	localparam int unsigned CfgIdxW = 3;

	typedef logic [TimeW-1:0]  ms_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	// Register indexes on the configuration port.
	localparam cfg_idx_t REG_ERROR_GAP   = 3'd0;
	localparam cfg_idx_t REG_ERROR_PULSE = 3'd1;
	localparam cfg_idx_t REG_ERROR_PAUSE = 3'd2;
	localparam cfg_idx_t REG_IDLE_OFF    = 3'd3;
	localparam cfg_idx_t REG_IDLE_ON     = 3'd4;
	localparam cfg_idx_t REG_REMOVED     = 3'd5;

	// Reset values of the timing registers.
	localparam ms_t RST_ERROR_GAP   = 16'd500;
	localparam ms_t RST_ERROR_PULSE = 16'd400;
	localparam ms_t RST_ERROR_PAUSE = 16'd1600;
	localparam ms_t RST_IDLE_OFF    = 16'd2000;
	localparam ms_t RST_IDLE_ON     = 16'd100;
	localparam ms_t RST_REMOVED     = 16'd200;

	// Input command codes.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	// Display mode codes as they arrive on mode_code.
	localparam logic [2:0] CODE_ERROR   = 3'd0;
	localparam logic [2:0] CODE_INIT    = 3'd1;
	localparam logic [2:0] CODE_IDLE    = 3'd2;
	localparam logic [2:0] CODE_NONE    = 3'd3;
	localparam logic [2:0] CODE_REMOVED = 3'd4;

	// Stored display mode.
	typedef enum logic [4:0] {
		MD_ERROR   = 5'b00001,
		MD_INIT    = 5'b00010,
		MD_IDLE    = 5'b00100,
		MD_NONE    = 5'b01000,
		MD_REMOVED = 5'b10000
	} mode_t;

	// Pattern phase. Two-phase blinks use FIRST for off and FLASH_ON for on.
	typedef enum logic [3:0] {
		PH_FIRST     = 4'b0001,
		PH_FLASH_OFF = 4'b0010,
		PH_FLASH_ON  = 4'b0100,
		PH_PAUSE     = 4'b1000
	} phase_t;

	// Timing register file contents.
	typedef struct packed {
		ms_t error_gap;
		ms_t error_pulse;
		ms_t error_pause;
		ms_t idle_off;
		ms_t idle_on;
		ms_t removed_half;
	} cfg_regs_t;

endpackage

FILE: rtl/status_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// status_led_blink_sequencer
// Status LED blink-code generator driven by tick and set-mode items.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register, to out_valid.
// Throughput: one item per cycle; the input register and the result register
// are updated together, so input stall rises only while a result is stalled.
// Reset: mode none, pattern LED state off (led_on itself is not reset), timing registers at defaults.
// ----------------------------------------------------------------------------
module status_led_blink_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input items.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [2:0]           mode_code,
	input  slbseq_pkg::count_t   error_count,
	// Result items.
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 led_on,
	// Configuration writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  slbseq_pkg::cfg_idx_t cfg_index,
	input  slbseq_pkg::ms_t      cfg_data
);
	import slbseq_pkg::*;

	logic      valid_s1;
	logic      command_s1;
	logic [2:0] mode_code_s1;
	count_t    error_count_s1;
	logic      out_valid_q;
	logic      led_q;
	logic      advance;
	logic      in_take;
	logic      led_next;
	cfg_regs_t regs;

	assign cfg_ready = 1'b1;

	slbseq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs)
	);

	// The held item moves into the result register when that is free.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1     <= command;
			mode_code_s1   <= mode_code;
			error_count_s1 <= error_count;
		end
	end

	slbseq_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.command     (command_s1),
		.mode_code   (mode_code_s1),
		.error_count (error_count_s1),
		.regs        (regs),
		.led_next    (led_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_q <= led_next;
		end
	end

	assign out_valid = out_valid_q;
	assign led_on    = led_q;

endmodule

FILE: rtl/slbseq_cfg.sv
// ----------------------------------------------------------------------------
// slbseq_cfg
// Timing register file, written through a write-enable port.
// ----------------------------------------------------------------------------
module slbseq_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  slbseq_pkg::cfg_idx_t  wr_index,
	input  slbseq_pkg::ms_t       wr_data,
	output slbseq_pkg::cfg_regs_t regs
);
	import slbseq_pkg::*;

	cfg_regs_t regs_q;

	// Writes to indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.error_gap    <= RST_ERROR_GAP;
			regs_q.error_pulse  <= RST_ERROR_PULSE;
			regs_q.error_pause  <= RST_ERROR_PAUSE;
			regs_q.idle_off     <= RST_IDLE_OFF;
			regs_q.idle_on      <= RST_IDLE_ON;
			regs_q.removed_half <= RST_REMOVED;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ERROR_GAP:   regs_q.error_gap    <= wr_data;
				REG_ERROR_PULSE: regs_q.error_pulse  <= wr_data;
				REG_ERROR_PAUSE: regs_q.error_pause  <= wr_data;
				REG_IDLE_OFF:    regs_q.idle_off     <= wr_data;
				REG_IDLE_ON:     regs_q.idle_on      <= wr_data;
				REG_REMOVED:     regs_q.removed_half <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

FILE: rtl/slbseq_seq.sv
// ----------------------------------------------------------------------------
// slbseq_seq
// Pattern state and its next-state logic; one item is applied per enable.
// ----------------------------------------------------------------------------
module slbseq_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic                  command,
	input  logic [2:0]            mode_code,
	input  slbseq_pkg::count_t    error_count,
	input  slbseq_pkg::cfg_regs_t regs,
	output logic                  led_next
);
	import slbseq_pkg::*;

	mode_t  mode_q, mode_d;
	phase_t phase_q, phase_d;
	ms_t    cnt_q, cnt_d;
	count_t done_q, done_d;
	count_t total_q, total_d;
	logic   led_q, led_d;

	ms_t    dur_raw;
	ms_t    dur;
	ms_t    cnt_inc;
	logic   over;
	count_t done_inc;

	// Duration of the current phase; a zero register acts as one.
	always_comb begin
		dur_raw = regs.error_gap;
		unique case (mode_q)
			MD_ERROR: begin
				unique case (phase_q)
					PH_FIRST:     dur_raw = regs.error_gap;
					PH_FLASH_OFF: dur_raw = regs.error_pulse;
					PH_FLASH_ON:  dur_raw = regs.error_pulse;
					PH_PAUSE:     dur_raw = regs.error_pause;
					default:      dur_raw = regs.error_pause;
				endcase
			end
			MD_IDLE:    dur_raw = (phase_q == PH_FIRST) ? regs.idle_off : regs.idle_on;
			MD_REMOVED: dur_raw = regs.removed_half;
			default:    dur_raw = regs.error_gap;
		endcase
		dur = (dur_raw == '0) ? ms_t'(1) : dur_raw;
	end

	// Saturating millisecond count and phase-end compare.
	assign cnt_inc  = (cnt_q != '1) ? cnt_q + ms_t'(1) : cnt_q;
	assign over     = (cnt_inc >= dur);
	assign done_inc = done_q + count_t'(1);

	// Next pattern state for a set command or a tick.
	always_comb begin
		mode_d  = mode_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		done_d  = done_q;
		total_d = total_q;
		led_d   = led_q;
		if (command == CMD_SET) begin
			unique case (mode_code)
				CODE_ERROR:   mode_d = MD_ERROR;
				CODE_INIT:    mode_d = MD_INIT;
				CODE_IDLE:    mode_d = MD_IDLE;
				CODE_REMOVED: mode_d = MD_REMOVED;
				default:      mode_d = MD_NONE;
			endcase
			phase_d = PH_FIRST;
			cnt_d   = '0;
			done_d  = '0;
			if (mode_code == CODE_ERROR) begin
				total_d = error_count;
			end
			led_d = (mode_code == CODE_INIT);
		end else begin
			unique case (mode_q)
				MD_ERROR: begin
					cnt_d = over ? '0 : cnt_inc;
					if (over) begin
						unique case (phase_q)
							PH_FIRST: begin
								done_d  = '0;
								phase_d = (total_q == '0) ? PH_PAUSE : PH_FLASH_OFF;
								led_d   = 1'b0;
							end
							PH_FLASH_OFF: begin
								phase_d = PH_FLASH_ON;
								led_d   = 1'b1;
							end
							PH_FLASH_ON: begin
								done_d  = done_inc;
								phase_d = (done_inc < total_q) ? PH_FLASH_OFF : PH_PAUSE;
								led_d   = 1'b0;
							end
							default: begin
								phase_d = PH_FIRST;
								led_d   = 1'b0;
							end
						endcase
					end
				end
				MD_IDLE, MD_REMOVED: begin
					cnt_d = over ? '0 : cnt_inc;
					if (over) begin
						if (phase_q == PH_FIRST) begin
							phase_d = PH_FLASH_ON;
							led_d   = 1'b1;
						end else begin
							phase_d = PH_FIRST;
							led_d   = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MD_NONE;
			phase_q <= PH_FIRST;
			cnt_q   <= '0;
			done_q  <= '0;
			total_q <= '0;
			led_q   <= 1'b0;
		end else if (step_en) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
			total_q <= total_d;
			led_q   <= led_d;
		end
	end

	assign led_next = led_d;

endmodule

FILE: rtl/slbseq_chk.sv
// ----------------------------------------------------------------------------
// slbseq_chk
// Port-level checks for the status LED blink sequencer, bound to the top.
// ----------------------------------------------------------------------------
module slbseq_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic led_on
);

	// A stalled result stays and keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_on))
	else $error("stalled result changed");

	// The input side stalls only behind a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
	else $error("input stalled while result path is free");

	// A result appearing on an empty output follows an accepted item that
	// passed through the input register and then the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
	else $error("result without an accepted item");

	// Back to back accepted items keep results flowing without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && out_valid && !out_stall |=> ##1 out_valid)
	else $error("result path dropped an item");

endmodule

bind status_led_blink_sequencer slbseq_chk u_slbseq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.led_on    (led_on)
);

FILE: tb/tb_status_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// tb_status_led_blink_sequencer
// Self-checking bench for the status LED blink sequencer.
// ----------------------------------------------------------------------------
// A scoreboard object tracks the display mode, the pattern phase and the
// millisecond counter for every accepted tick or set item. From that state it
// predicts the LED level that the block reports for the item. A short
// directed run covers each mode, unknown mode codes, a zero error count, a
// zero duration and writes to unused register indexes. Random phases follow
// under several timing settings, with random idling on both channels, one
// quiet stretch and one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_status_led_blink_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import slbseq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 190;
	localparam int unsigned HOLD_CYCLES = 64;

	// Register indexes past the end of the register list.
	localparam cfg_idx_t IDX_SPARE_LO = 3'd6;
	localparam cfg_idx_t IDX_SPARE_HI = 3'd7;

	// Mode codes outside the defined set.
	localparam logic [2:0] CODE_SPARE_LO = 3'd5;
	localparam logic [2:0] CODE_SPARE_HI = 3'd7;

	// Scoreboard: LED pattern prediction and in-order result check.
	class led_pattern_scoreboard;
		cfg_regs_t regs;
		mode_t cur_mode;
		phase_t cur_phase;
		ms_t ms_count;
		count_t flashes_done;
		count_t flashes_total;
		logic lit;
		logic expected_led[$];
		int unsigned errors;

		function new();
			regs.error_gap = RST_ERROR_GAP;
			regs.error_pulse = RST_ERROR_PULSE;
			regs.error_pause = RST_ERROR_PAUSE;
			regs.idle_off = RST_IDLE_OFF;
			regs.idle_on = RST_IDLE_ON;
			regs.removed_half = RST_REMOVED;
			cur_mode = MD_NONE;
			cur_phase = PH_FIRST;
			ms_count = '0;
			flashes_done = '0;
			flashes_total = '0;
			lit = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, ms_t val);
			case (idx)
				REG_ERROR_GAP: begin
					regs.error_gap = val;
				end
				REG_ERROR_PULSE: begin
					regs.error_pulse = val;
				end
				REG_ERROR_PAUSE: begin
					regs.error_pause = val;
				end
				REG_IDLE_OFF: begin
					regs.idle_off = val;
				end
				REG_IDLE_ON: begin
					regs.idle_on = val;
				end
				REG_REMOVED: begin
					regs.removed_half = val;
				end
				default: begin
				end
			endcase
		endfunction

		// Counts one millisecond and reports whether the current span is over.
		// A span of zero behaves as one millisecond.
		function bit span_done(ms_t span);
			if (span == '0) begin
				span = 16'd1;
			end
			if (ms_count != 16'hFFFF) begin
				ms_count = ms_count + 16'd1;
			end
			if (ms_count >= span) begin
				ms_count = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Gap, flash bursts and pause of the error pattern.
		function void step_error();
			case (cur_phase)
				PH_FIRST: begin
					if (span_done(regs.error_gap)) begin
						flashes_done = '0;
						cur_phase = (flashes_total == '0) ? PH_PAUSE : PH_FLASH_OFF;
						lit = 1'b0;
					end
				end
				PH_FLASH_OFF: begin
					if (span_done(regs.error_pulse)) begin
						cur_phase = PH_FLASH_ON;
						lit = 1'b1;
					end
				end
				PH_FLASH_ON: begin
					if (span_done(regs.error_pulse)) begin
						flashes_done = flashes_done + 8'd1;
						cur_phase = (flashes_done < flashes_total) ? PH_FLASH_OFF : PH_PAUSE;
						lit = 1'b0;
					end
				end
				default: begin
					if (span_done(regs.error_pause)) begin
						cur_phase = PH_FIRST;
						lit = 1'b0;
					end
				end
			endcase
		endfunction

		// Plain off/on blink used by idle and top-removed modes.
		function void step_blink(ms_t off_span, ms_t on_span);
			if (cur_phase == PH_FIRST) begin
				if (span_done(off_span)) begin
					cur_phase = PH_FLASH_ON;
					lit = 1'b1;
				end
			end else begin
				if (span_done(on_span)) begin
					cur_phase = PH_FIRST;
					lit = 1'b0;
				end
			end
		endfunction

		// Applies one accepted item and queues the LED level it leaves.
		function void note_input(logic cmd, logic [2:0] code, count_t cnt);
			if (cmd == CMD_SET) begin
				case (code)
					CODE_ERROR: begin
						cur_mode = MD_ERROR;
					end
					CODE_INIT: begin
						cur_mode = MD_INIT;
					end
					CODE_IDLE: begin
						cur_mode = MD_IDLE;
					end
					CODE_REMOVED: begin
						cur_mode = MD_REMOVED;
					end
					default: begin
						cur_mode = MD_NONE;
					end
				endcase
				cur_phase = PH_FIRST;
				ms_count = '0;
				flashes_done = '0;
				if (cur_mode == MD_ERROR) begin
					flashes_total = cnt;
				end
				lit = (cur_mode == MD_INIT);
			end else begin
				case (cur_mode)
					MD_ERROR: begin
						step_error();
					end
					MD_IDLE: begin
						step_blink(regs.idle_off, regs.idle_on);
					end
					MD_REMOVED: begin
						step_blink(regs.removed_half, regs.removed_half);
					end
					default: begin
					end
				endcase
			end
			expected_led.push_back(lit);
		endfunction

		function void check_result(logic got);
			logic want;
			if (expected_led.size() == 0) begin
				$error("led_on: result with no item pending, actual %0b", got);
				errors++;
			end else begin
				want = expected_led.pop_front();
				if (got !== want) begin
					$error("led_on mismatch: expected %0b, actual %0b", want, got);
					errors++;
				end
			end
		endfunction

		function int unsigned pending();
			return expected_led.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_TICK;
	logic [2:0] mode_code = CODE_NONE;
	count_t error_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic led_on;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = REG_ERROR_GAP;
	ms_t cfg_data = '0;

	led_pattern_scoreboard sb = new();

	int unsigned tx_idle_pct = 31;
	int unsigned rx_idle_pct = 31;
	int unsigned holds_asked = 0;

	status_led_blink_sequencer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.mode_code   (mode_code),
		.error_count (error_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_on      (led_on),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Result check on every accepted output item.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(led_on);
		end
	end

	// Output stall: random, quiet on request, or one long hold when asked.
	initial begin : stall_driver
		int unsigned holds_done;
		int unsigned held;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				out_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++) begin
					@(posedge clk);
				end
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
			@(posedge clk);
		end
		$display("status_led_blink_sequencer test failed");
		$finish;
	end

	// Offers one item, with random idle cycles ahead of it, and waits until
	// the block takes it.
	task automatic send_item(logic cmd, logic [2:0] code, count_t cnt);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		mode_code <= code;
		error_count <= cnt;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_input(cmd, code, cnt);
	endtask

	task automatic send_ticks(int unsigned n);
		repeat (n) begin
			send_item(CMD_TICK, CODE_ERROR, '0);
		end
	endtask

	// Mostly ticks; sets lean toward error mode with few flashes so that
	// whole bursts play out. Unused fields of a tick carry noise.
	task automatic send_random_item();
		logic [2:0] code;
		count_t cnt;
		int unsigned pick;
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2, 3: begin
				code = CODE_ERROR;
			end
			4: begin
				code = CODE_INIT;
			end
			5: begin
				code = CODE_IDLE;
			end
			6: begin
				code = CODE_NONE;
			end
			7, 8: begin
				code = CODE_REMOVED;
			end
			default: begin
				code = 3'($urandom_range(CODE_SPARE_HI, CODE_SPARE_LO));
			end
		endcase
		cnt = ($urandom_range(7) == 0) ? count_t'($urandom()) : count_t'($urandom_range(4));
		if ($urandom_range(99) < 6) begin
			send_item(CMD_SET, code, cnt);
		end else begin
			send_item(CMD_TICK, code, cnt);
		end
	endtask

	// Stops offering items and waits until every result is back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Writes the six timing registers back to back; the block is idle here.
	task automatic write_timing(ms_t vals[6]);
		int unsigned i;
		for (i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) begin
				@(posedge clk);
			end
			sb.set_reg(cfg_idx_t'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic write_spare(cfg_idx_t idx, ms_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.set_reg(idx, val);
	endtask

	// Timing for one random phase: short spans, all ones, all zeros, all
	// maximum, then mixes with the odd zero or full-width value.
	task automatic load_phase_timing(int unsigned ph);
		ms_t vals[6];
		int unsigned i;
		int unsigned pick;
		for (i = 0; i < 6; i++) begin
			pick = $urandom_range(9);
			case (ph)
				0: begin
					vals[i] = ms_t'($urandom_range(4, 1));
				end
				1: begin
					vals[i] = 16'd1;
				end
				2: begin
					vals[i] = '0;
				end
				3: begin
					vals[i] = 16'hFFFF;
				end
				default: begin
					if (pick == 0) begin
						vals[i] = '0;
					end else if (pick == 1) begin
						vals[i] = ms_t'($urandom());
					end else begin
						vals[i] = ms_t'($urandom_range(8, 1));
					end
				end
			endcase
		end
		write_timing(vals);
	endtask

	initial begin : stimulus
		ms_t short_timing[6];
		int unsigned ph;
		int unsigned n;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset timing: tick with no mode, init, unknown codes, back to none.
		send_item(CMD_TICK, CODE_ERROR, '0);
		send_item(CMD_SET, CODE_INIT, 8'hFF);
		send_item(CMD_TICK, CODE_ERROR, '0);
		send_item(CMD_SET, CODE_SPARE_LO, '0);
		send_item(CMD_SET, CODE_SPARE_HI, '0);
		send_item(CMD_SET, CODE_NONE, '0);
		drain();

		// Writes past the register list, then short spans and a zero gap.
		write_spare(IDX_SPARE_LO, 16'hFFFF);
		write_spare(IDX_SPARE_HI, 16'hFFFF);
		short_timing = '{16'd0, 16'd1, 16'd2, 16'd2, 16'd1, 16'd1};
		write_timing(short_timing);

		// One full flash burst, a burst with no flashes at all, then idle and removed blinks.
		send_item(CMD_SET, CODE_ERROR, 8'd1);
		send_ticks(5);
		send_item(CMD_SET, CODE_ERROR, 8'd0);
		send_ticks(3);
		send_item(CMD_SET, CODE_IDLE, '0);
		send_ticks(3);
		send_item(CMD_SET, CODE_REMOVED, '0);
		send_ticks(2);
		// A long burst cut short by a new set.
		send_item(CMD_SET, CODE_ERROR, 8'hFF);
		send_ticks(1);
		send_item(CMD_SET, CODE_INIT, '0);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			load_phase_timing(ph);
			tx_idle_pct = (ph == 5) ? 0 : 31;
			rx_idle_pct = (ph == 5) ? 0 : 31;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Long output hold with the sender offering items back to back.
				if (ph == 4 && n == 40) begin
					holds_asked++;
					tx_idle_pct = 0;
				end
				if (ph == 4 && n == 120) begin
					tx_idle_pct = 31;
				end
				send_random_item();
			end
		end
		drain();
		repeat (10) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status_led_blink_sequencer test passed");
		end else begin
			$display("status_led_blink_sequencer test failed");
		end
		$finish;
	end

endmodule
